// ----- hw/rtl/cpu_eau_pkg.sv -----
// shared types and codes for the 6502 effective address unit
package cpu_eau_pkg;

    // input beat kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_RESP  = 1'b1;

    // addressing mode codes
    localparam logic [3:0] MODE_IMP  = 4'd0;
    localparam logic [3:0] MODE_IMM  = 4'd1;
    localparam logic [3:0] MODE_REL  = 4'd2;
    localparam logic [3:0] MODE_ZP   = 4'd3;
    localparam logic [3:0] MODE_ZPX  = 4'd4;
    localparam logic [3:0] MODE_ZPY  = 4'd5;
    localparam logic [3:0] MODE_ABS  = 4'd6;
    localparam logic [3:0] MODE_ABSX = 4'd7;
    localparam logic [3:0] MODE_ABSY = 4'd8;
    localparam logic [3:0] MODE_INDX = 4'd9;
    localparam logic [3:0] MODE_INDY = 4'd10;
    localparam logic [3:0] MODE_JMPI = 4'd11;

    // result kinds
    localparam logic [1:0] RES_REQ  = 2'd0;
    localparam logic [1:0] RES_DONE = 2'd1;
    localparam logic [1:0] RES_ERR  = 2'd2;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_OPERAND  = 3'd1,
        PH_OPER_HI  = 3'd2,
        PH_PTR_LO   = 3'd3,
        PH_PTR_HI   = 3'd4
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [3:0]  mode;
        logic [15:0] pc_in;
        logic [7:0]  x_index;
        logic [7:0]  y_index;
        logic [7:0]  read_data;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] read_addr;
        logic [15:0] eff_addr;
        logic [15:0] pc_out;
        logic        page_crossed;
    } t_out_beat;

endpackage

// ----- hw/rtl/cpu_eau_input_stage.sv -----
// input register for incoming beats
module cpu_eau_input_stage
    import cpu_eau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_beat i_beat,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    t_in_beat r_beat;

    // room when empty or when the held beat moves on this cycle
    assign o_ready = !r_valid || i_take;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- hw/rtl/cpu_eau_sequencer.sv -----
// addressing mode sequencer: held state and one step per beat
module cpu_eau_sequencer
    import cpu_eau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_beat  i_beat,
    output logic      o_has_result,
    output t_out_beat o_result
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_mode, n_mode;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_x, n_x;
    logic [7:0]  r_y, n_y;
    logic [15:0] r_ptr, n_ptr;
    logic [7:0]  r_low, n_low;

    logic [7:0]  d;
    logic [7:0]  zp_x;
    logic [7:0]  zp_y;
    logic [15:0] word;
    logic [15:0] word_x;
    logic [15:0] word_y;
    logic [15:0] ptr_next;
    logic        start;

    // shared address arithmetic
    assign start    = (i_beat.kind == KIND_START);
    assign d        = i_beat.read_data;
    assign zp_x     = d + r_x;
    assign zp_y     = d + r_y;
    assign word     = {d, r_low};
    assign word_x   = word + {8'h00, r_x};
    assign word_y   = word + {8'h00, r_y};
    // pointer high byte read stays within the pointer's page
    assign ptr_next = {r_ptr[15:8], r_ptr[7:0] + 8'd1};

    // next phase
    always_comb begin
        n_phase = PH_IDLE;
        if (start) begin
            case (i_beat.mode)
                MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_INDX, MODE_INDY,
                MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_JMPI: begin
                    n_phase = PH_OPERAND;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else begin
            case (r_phase)
                PH_OPERAND: begin
                    case (r_mode)
                        MODE_INDX, MODE_INDY: n_phase = PH_PTR_LO;
                        MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_JMPI: n_phase = PH_OPER_HI;
                        default: n_phase = PH_IDLE;
                    endcase
                end
                PH_OPER_HI: begin
                    n_phase = (r_mode == MODE_JMPI) ? PH_PTR_LO : PH_IDLE;
                end
                PH_PTR_LO: begin
                    n_phase = PH_PTR_HI;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // result and held datapath
    always_comb begin
        n_mode       = r_mode;
        n_pc         = r_pc;
        n_x          = r_x;
        n_y          = r_y;
        n_ptr        = r_ptr;
        n_low        = r_low;
        o_has_result = 1'b1;
        o_result     = '0;
        o_result.pc_out = r_pc;
        if (start) begin
            n_mode = i_beat.mode;
            n_x    = i_beat.x_index;
            n_y    = i_beat.y_index;
            n_ptr  = '0;
            n_low  = '0;
            case (i_beat.mode)
                MODE_IMM, MODE_REL: begin
                    n_pc                 = i_beat.pc_in + 16'd1;
                    o_result.result_kind = RES_DONE;
                    o_result.eff_addr    = i_beat.pc_in;
                end
                MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_INDX, MODE_INDY: begin
                    n_pc                 = i_beat.pc_in + 16'd1;
                    o_result.result_kind = RES_REQ;
                    o_result.read_addr   = i_beat.pc_in;
                end
                MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_JMPI: begin
                    n_pc                 = i_beat.pc_in + 16'd2;
                    o_result.result_kind = RES_REQ;
                    o_result.read_addr   = i_beat.pc_in;
                end
                default: begin
                    n_pc                 = i_beat.pc_in;
                    o_result.result_kind = RES_ERR;
                end
            endcase
            o_result.pc_out = n_pc;
        end else begin
            case (r_phase)
                PH_OPERAND: begin
                    case (r_mode)
                        MODE_ZP: begin
                            o_result.result_kind = RES_DONE;
                            o_result.eff_addr    = {8'h00, d};
                        end
                        MODE_ZPX: begin
                            o_result.result_kind = RES_DONE;
                            o_result.eff_addr    = {8'h00, zp_x};
                        end
                        MODE_ZPY: begin
                            o_result.result_kind = RES_DONE;
                            o_result.eff_addr    = {8'h00, zp_y};
                        end
                        MODE_INDX: begin
                            n_ptr                = {8'h00, zp_x};
                            o_result.result_kind = RES_REQ;
                            o_result.read_addr   = {8'h00, zp_x};
                        end
                        MODE_INDY: begin
                            n_ptr                = {8'h00, d};
                            o_result.result_kind = RES_REQ;
                            o_result.read_addr   = {8'h00, d};
                        end
                        MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_JMPI: begin
                            n_low                = d;
                            o_result.result_kind = RES_REQ;
                            o_result.read_addr   = r_pc - 16'd1;
                        end
                        default: begin
                            o_result.result_kind = RES_ERR;
                        end
                    endcase
                end
                PH_OPER_HI: begin
                    case (r_mode)
                        MODE_ABSX: begin
                            o_result.result_kind  = RES_DONE;
                            o_result.eff_addr     = word_x;
                            o_result.page_crossed = (word_x[15:8] != word[15:8]);
                        end
                        MODE_ABSY: begin
                            o_result.result_kind  = RES_DONE;
                            o_result.eff_addr     = word_y;
                            o_result.page_crossed = (word_y[15:8] != word[15:8]);
                        end
                        MODE_JMPI: begin
                            n_ptr                = word;
                            o_result.result_kind = RES_REQ;
                            o_result.read_addr   = word;
                        end
                        default: begin
                            o_result.result_kind = RES_DONE;
                            o_result.eff_addr    = word;
                        end
                    endcase
                end
                PH_PTR_LO: begin
                    n_low                = d;
                    o_result.result_kind = RES_REQ;
                    o_result.read_addr   = ptr_next;
                end
                PH_PTR_HI: begin
                    o_result.result_kind = RES_DONE;
                    if (r_mode == MODE_INDY) begin
                        o_result.eff_addr     = word_y;
                        o_result.page_crossed = (word_y[15:8] != word[15:8]);
                    end else begin
                        o_result.eff_addr = word;
                    end
                end
                default: begin
                    // response with nothing in flight is dropped
                    o_has_result = 1'b0;
                end
            endcase
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    // held operands, only read while a sequence runs
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_mode <= n_mode;
            r_pc   <= n_pc;
            r_x    <= n_x;
            r_y    <= n_y;
            r_ptr  <= n_ptr;
            r_low  <= n_low;
        end
    end

endmodule

// ----- hw/rtl/cpu_eau_output_stage.sv -----
// result register toward the consumer
module cpu_eau_output_stage
    import cpu_eau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_beat i_beat,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_beat
);

    logic      r_valid;
    t_out_beat r_beat;

    // free when empty or when the held beat leaves this cycle
    assign o_free = !r_valid || i_ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- hw/rtl/cpu_effective_address_unit.sv -----
// top level of the 6502 effective address unit
// Takes one input beat per cycle and gives at most one result beat for it (input register,
// then one step of the mode sequencer into the result register); a start beat sets the
// mode, pc and indexes, each read request is answered by a response beat carrying the byte,
// and the last response (or an IMM/REL start) yields eff_addr, pc_out and page_crossed.
// Throughput is one beat per cycle, limited only by the consumer taking results.
module cpu_effective_address_unit
    import cpu_eau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic      in_valid;
    t_in_beat  in_beat;
    logic      out_free;
    logic      step;
    logic      has_result;
    t_out_beat result;

    // a held beat steps the sequencer whenever the result register has room
    assign step = in_valid && out_free;

    cpu_eau_input_stage u_input (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (i_in_beat),
        .i_take  (step),
        .o_valid (in_valid),
        .o_beat  (in_beat)
    );

    cpu_eau_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_beat       (in_beat),
        .o_has_result (has_result),
        .o_result     (result)
    );

    cpu_eau_output_stage u_output (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && has_result),
        .i_beat  (result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_beat)
    );

    // page flag only on a finished address
    a_page_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.page_crossed) |-> (o_out_beat.result_kind == RES_DONE))
        else $error("page flag on a non-done result");

    // read address only on a request, effective address only on done
    a_addr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_beat.result_kind == RES_DONE || o_out_beat.eff_addr == 16'h0000)
                      && (o_out_beat.result_kind != RES_REQ || o_out_beat.eff_addr == 16'h0000)
                      && (o_out_beat.result_kind == RES_REQ || o_out_beat.read_addr == 16'h0000)))
        else $error("address field set for wrong result kind");

    // a stalled result blocks the sequencer
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !step)
        else $error("sequencer stepped into a full result register");

endmodule
